@@ rtl/core/dnp_pkg.sv @@
// Package for the decimal number parser: character codes, pipeline widths,
// the power-of-ten table and the structs passed between the parser and the
// Q16.16 converter. No dependencies.
package dnp_pkg;

    localparam int MANTISSA_BITS_DEF = 31;

    // The remainder of the conversion divider stays below the divisor unless
    // the quotient saturates, and the largest divisor (10^15) needs 50 bits.
    localparam int REM_W      = 50;
    // Quotient bits kept by the divider: floor(a * 2^17 / 10^f) below 2^33.
    localparam int QUO_W      = 33;
    localparam int Q_FRAC     = 16;
    localparam int EXT_W      = REM_W + Q_FRAC;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [3:0] FRAC_MAX = 4'd15;

    localparam logic [QUO_W-1:0] Q_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W-1:0] Q_NEG_LIM = 33'h0_8000_0000;

    typedef struct packed {
        logic [3:0] frac;
        logic       neg;
        logic       ovf;
        logic       found;
    } t_emit_flags;

    typedef struct packed {
        logic             valid;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] bits;
        logic [3:0]       frac;
        logic             neg;
        logic             found;
        logic             sat;
        logic             big;
        logic [31:0]      mant;
    } t_div_stage;

    typedef struct packed {
        logic [31:0] value_q16;
        logic [31:0] mantissa;
        logic [3:0]  frac_digits;
        logic        found;
        logic        saturated;
    } t_result;

    function automatic logic [REM_W-1:0] pow10(input logic [3:0] n);
        logic [REM_W-1:0] p;
        case (n)
            4'd0:    p = 50'd1;
            4'd1:    p = 50'd10;
            4'd2:    p = 50'd100;
            4'd3:    p = 50'd1000;
            4'd4:    p = 50'd10000;
            4'd5:    p = 50'd100000;
            4'd6:    p = 50'd1000000;
            4'd7:    p = 50'd10000000;
            4'd8:    p = 50'd100000000;
            4'd9:    p = 50'd1000000000;
            4'd10:   p = 50'd10000000000;
            4'd11:   p = 50'd100000000000;
            4'd12:   p = 50'd1000000000000;
            4'd13:   p = 50'd10000000000000;
            4'd14:   p = 50'd100000000000000;
            default: p = 50'd1000000000000000;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/core/dnp_parser.sv @@
// Byte-level parser: search, sign, digits and point, with the saturating
// digit accumulator. Emits a snapshot when a number ends and at end of data.
// Depends on dnp_pkg.
module dnp_parser import dnp_pkg::*; #(
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_char,
    input  logic                     i_eod,
    output logic                     o_emit,
    output logic [MANTISSA_BITS-1:0] o_emit_acc,
    output t_emit_flags              o_emit_flags
);

    localparam int ACC_W = MANTISSA_BITS + 4;

    logic                     r_in_number, n_in_number;
    logic                     r_neg, n_neg;
    logic                     r_point, n_point;
    logic                     r_ovf, n_ovf;
    logic [MANTISSA_BITS-1:0] r_acc, n_acc;
    logic [3:0]               r_frac, n_frac;

    logic             is_digit;
    logic             is_start;
    logic             cont;
    logic [ACC_W-1:0] acc_next;

    always_comb begin
        is_digit = i_char inside {[CH_ZERO:CH_NINE]};
        is_start = is_digit || (i_char inside {CH_MINUS, CH_DOT});
        cont     = !i_eod && r_in_number &&
                   (is_digit || (i_char == CH_DOT && !r_point));

        // A byte that ends the number is looked at again from a clean state.
        if (cont) begin
            n_in_number = r_in_number;
            n_neg       = r_neg;
            n_point     = r_point;
            n_ovf       = r_ovf;
            n_acc       = r_acc;
            n_frac      = r_frac;
        end else begin
            n_in_number = 1'b0;
            n_neg       = 1'b0;
            n_point     = 1'b0;
            n_ovf       = 1'b0;
            n_acc       = '0;
            n_frac      = 4'd0;
        end

        acc_next = (ACC_W'(n_acc) << 3) + (ACC_W'(n_acc) << 1) + ACC_W'(i_char[3:0]);

        if (!i_eod && (cont || is_start)) begin
            n_in_number = 1'b1;
            if (i_char == CH_MINUS) begin
                n_neg = 1'b1;
            end else if (i_char == CH_DOT) begin
                n_point = 1'b1;
            end else begin
                if (acc_next[ACC_W-1:MANTISSA_BITS] != '0) begin
                    n_acc = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = acc_next[MANTISSA_BITS-1:0];
                end
                if (n_point) begin
                    if (n_frac == FRAC_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_frac = n_frac + 4'd1;
                    end
                end
            end
        end
    end

    // While searching the state holds its reset values, so an end-of-data
    // item in search emits the all-zero result with found clear.
    assign o_emit             = i_accept && (i_eod || (r_in_number && !cont));
    assign o_emit_acc         = r_acc;
    assign o_emit_flags.frac  = r_frac;
    assign o_emit_flags.neg   = r_neg;
    assign o_emit_flags.ovf   = r_ovf;
    assign o_emit_flags.found = r_in_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_neg       <= 1'b0;
            r_point     <= 1'b0;
            r_ovf       <= 1'b0;
            r_acc       <= '0;
            r_frac      <= 4'd0;
        end else if (i_accept) begin
            r_in_number <= n_in_number;
            r_neg       <= n_neg;
            r_point     <= n_point;
            r_ovf       <= n_ovf;
            r_acc       <= n_acc;
            r_frac      <= n_frac;
        end
    end

endmodule

@@ rtl/core/dnp_q16_conv.sv @@
// Q16.16 conversion pipeline: snapshot register, a setup stage, one
// restoring-division step per stage by 10^frac, then rounding and saturation.
// Depends on dnp_pkg.
module dnp_q16_conv import dnp_pkg::*; #(
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_emit,
    input  logic [MANTISSA_BITS-1:0] i_emit_acc,
    input  t_emit_flags              i_emit_flags,
    output logic                     o_valid,
    output t_result                  o_result
);

    logic                     r_snap_valid;
    logic [MANTISSA_BITS-1:0] r_snap_acc;
    t_emit_flags              r_snap_flags;

    t_div_stage r_div [0:QUO_W];
    t_div_stage n_div [0:QUO_W];

    logic [EXT_W-1:0] acc_ext;
    logic [REM_W-1:0] prep_div;
    logic             mant_big;
    logic [30:0]      mag;

    logic [REM_W:0]   trial;
    logic [REM_W-1:0] dvs;
    logic             ge;

    t_div_stage       last;
    logic [QUO_W:0]   sum;
    logic [QUO_W-1:0] q;
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] qs;
    logic             over;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_snap_valid <= i_emit;
            r_snap_acc   <= i_emit_acc;
            r_snap_flags <= i_emit_flags;
        end
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end
    end

    // Setup: the dividend is acc * 2^17. Its part above the low 33 bits,
    // acc >> 16, starts as the remainder; if it already reaches the divisor
    // the quotient does not fit and the result saturates.
    always_comb begin
        acc_ext  = EXT_W'(r_snap_acc);
        prep_div = pow10(r_snap_flags.frac);
        mant_big = acc_ext[EXT_W-1:31] != '0;
        mag      = mant_big ? 31'h7FFF_FFFF : acc_ext[30:0];

        n_div[0].valid = r_snap_valid;
        n_div[0].rem   = acc_ext[EXT_W-1:Q_FRAC];
        n_div[0].bits  = {acc_ext[Q_FRAC-1:0], (QUO_W-Q_FRAC)'(0)};
        n_div[0].frac  = r_snap_flags.frac;
        n_div[0].neg   = r_snap_flags.neg;
        n_div[0].found = r_snap_flags.found;
        n_div[0].sat   = r_snap_flags.ovf | mant_big;
        n_div[0].big   = acc_ext[EXT_W-1:Q_FRAC] >= prep_div;
        n_div[0].mant  = r_snap_flags.neg ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
    end

    // Each stage shifts in the next dividend bit and produces one quotient
    // bit; the quotient collects at the bottom of the bits field.
    always_comb begin
        trial = '0;
        dvs   = '0;
        ge    = 1'b0;
        for (int k = 1; k <= QUO_W; k++) begin
            dvs      = pow10(r_div[k-1].frac);
            trial    = {r_div[k-1].rem, r_div[k-1].bits[QUO_W-1]};
            ge       = trial >= {1'b0, dvs};
            n_div[k] = r_div[k-1];
            if (ge) begin
                n_div[k].rem = REM_W'(trial - {1'b0, dvs});
            end else begin
                n_div[k].rem = trial[REM_W-1:0];
            end
            n_div[k].bits = {r_div[k-1].bits[QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QUO_W; k++) begin
            if (i_adv) begin
                r_div[k] <= n_div[k];
            end
            if (!i_rst_n) begin
                r_div[k].valid <= 1'b0;
            end
        end
    end

    // Round to nearest on the magnitude: halve the 17-fraction-bit quotient
    // with the dropped bit added back in.
    always_comb begin
        last = r_div[QUO_W];
        sum  = {1'b0, last.bits} + (QUO_W+1)'(1);
        q    = sum[QUO_W:1];
        lim  = last.neg ? Q_NEG_LIM : Q_POS_LIM;
        over = last.big || (q > lim);
        qs   = over ? lim : q;

        o_result.value_q16   = last.neg ? (32'd0 - qs[31:0]) : qs[31:0];
        o_result.mantissa    = last.mant;
        o_result.frac_digits = last.frac;
        o_result.found       = last.found;
        o_result.saturated   = last.sat | over;
    end

    assign o_valid = last.valid;

endmodule

@@ rtl/core/decimal_number_parser_unit.sv @@
// Top level of the ASCII decimal number parser: stream ports, the byte
// parser, the Q16.16 conversion pipeline and the result register.
// Depends on dnp_pkg, dnp_parser and dnp_q16_conv.
//
//   Channel  Direction  Handshake              Contents
//   s        in         i_s_tvalid/o_s_tready  one received byte or end-of-data
//   m        out        o_m_tvalid/i_m_tready  one parsed number
//
// One input item is taken per cycle unless the pipeline stalls. The item
// ending a number passes the snapshot register, the setup stage, the 33-step
// restoring divider by 10^frac_digits for the Q16.16 value, then the result register.
// Synchronous active-low reset empties the pipeline and returns the parser
// to searching. When the result register holds an untaken result and the
// last divider stage is full, the whole pipeline and the input side stall.
module decimal_number_parser_unit import dnp_pkg::*; #(
    parameter int MANTISSA_BITS = MANTISSA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // [7:0] char_byte
    input  logic                  i_s_tuser,  // [0] end_of_data
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [31:0] value_q16, [63:32] mantissa,
                                              // [67:64] frac_digits, [71:68] zero
    output logic [OUT_USER_W-1:0] o_m_tuser   // [0] found, [1] saturated
);

    logic                     adv;
    logic                     accept;
    logic                     emit;
    logic [MANTISSA_BITS-1:0] emit_acc;
    t_emit_flags              emit_flags;
    logic                     conv_valid;
    t_result                  conv_result;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    assign adv        = !conv_valid || !r_out_valid || i_m_tready;
    assign o_s_tready = adv;
    assign accept     = i_s_tvalid && adv;

    dnp_parser #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char       (i_s_tdata),
        .i_eod        (i_s_tuser),
        .o_emit       (emit),
        .o_emit_acc   (emit_acc),
        .o_emit_flags (emit_flags)
    );

    dnp_q16_conv #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_emit       (emit),
        .i_emit_acc   (emit_acc),
        .i_emit_flags (emit_flags),
        .o_valid      (conv_valid),
        .o_result     (conv_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && conv_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && conv_valid) begin
            r_out_data <= {(OUT_DATA_W-68)'(0), conv_result.frac_digits,
                           conv_result.mantissa, conv_result.value_q16};
            r_out_user <= {conv_result.saturated, conv_result.found};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

@@ rtl/core/dnp_checker.sv @@
// Port-level checks on the result stream of the decimal number parser,
// attached to the top level by the bind at the end of this file.
// Depends on dnp_pkg and decimal_number_parser_unit.
module dnp_checker import dnp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_m_tready,
    input logic                  o_m_tvalid,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [OUT_USER_W-1:0] o_m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // End of data while searching gives the all-zero result.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == '0) && !o_m_tuser[1])
        else $error("result without a number is not zero");

    // A negative Q16.16 value comes only from a negative mantissa.
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[31] |-> o_m_tdata[63])
        else $error("negative value with non-negative mantissa");

    // Without fraction digits or saturation the value is the mantissa shifted.
    a_integer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[67:64] == 4'd0) && !o_m_tuser[1] |->
        o_m_tdata[31:0] == {o_m_tdata[47:32], 16'h0000})
        else $error("integer value does not match mantissa");

endmodule

bind decimal_number_parser_unit dnp_checker u_dnp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
